### design/pmst_pkg.sv
// shared field widths for the minimum spanning tree block
package pmst_pkg;

  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int WEIGHT_IN_W = 16;
  localparam int COUNT_W     = 7;
  localparam int VERTEX_W    = 6;
  localparam int VLIMIT      = 64;

endpackage

### design/prim_minimum_spanning_tree_top.sv
// Prim minimum spanning tree over an adjacency matrix loaded entry by entry.
// Input channel (in_valid/in_stall): each item writes one matrix entry at
// (in_row, in_col) if in range; weight 0 means no edge. One entry per idle cycle.
// An item with in_last_entry set also writes its entry, then runs Prim from
// vertex 0 over the first V vertices, V being cfg vertex count clamped to
// 1..min(MAX_VERTICES, 64). in_stall stays high until the last pair leaves.
// Each Prim round is one scan sweep and one relax sweep through a shared
// comparator, one vertex per cycle against the distance ram, at most V-1
// rounds. Each output pair then passes the read, load and output states
// and waits in the output state while the receiver holds out_stall.
// Output channel (out_valid/out_stall): one (parent, child) item per vertex
// 1..V-1 in order, last one flagged out_last_pair; unreached vertices give
// out_connected 0 and parent 0. A stalled item holds its registers.
// Config (cfg_wr_en/cfg_wr_data) sets vertex count; write only while idle.
// Reset (rst_n, synchronous) sets vertex count to 1 and returns to idle;
// matrix entries are undefined until written.
module prim_minimum_spanning_tree_top
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ROW_W-1:0]       in_row,
  input  logic [COL_W-1:0]       in_col,
  input  logic [WEIGHT_IN_W-1:0] in_weight,
  input  logic                   in_last_entry,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VERTEX_W-1:0]    out_parent_vertex,
  output logic [VERTEX_W-1:0]    out_child_vertex,
  output logic                   out_connected,
  output logic                   out_last_pair
);

  localparam int VL = (MAX_VERTICES < VLIMIT) ? MAX_VERTICES : VLIMIT;
  localparam int VW = $clog2(VL);
  localparam int CW = VW + 1;
  localparam logic [COUNT_W-1:0] VL_C = COUNT_W'(VL);

  logic [COUNT_W-1:0] vcount_r, vcount_nxt;
  logic [CW-1:0]      nv;

  assign vcount_nxt = cfg_wr_en ? cfg_wr_data : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= COUNT_W'(1);
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  // clamp to the usable vertex range
  always_comb begin
    if (vcount_r == '0) begin
      nv = CW'(1);
    end else if (vcount_r > VL_C) begin
      nv = CW'(VL);
    end else begin
      nv = CW'(vcount_r);
    end
  end

  pmst_core #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .nv                (nv),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_weight         (in_weight),
    .in_last_entry     (in_last_entry),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_parent_vertex (out_parent_vertex),
    .out_child_vertex  (out_child_vertex),
    .out_connected     (out_connected),
    .out_last_pair     (out_last_pair)
  );

endmodule

### design/pmst_ram.sv
// generic single write port, single read port ram with registered read data
module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pmst_core.sv
// matrix store, prim sequencer with one shared compare unit, and pair output register
module pmst_core
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16,
  localparam int VL = (MAX_VERTICES < VLIMIT) ? MAX_VERTICES : VLIMIT,
  localparam int VW = $clog2(VL),
  localparam int CW = VW + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CW-1:0]          nv,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ROW_W-1:0]       in_row,
  input  logic [COL_W-1:0]       in_col,
  input  logic [WEIGHT_IN_W-1:0] in_weight,
  input  logic                   in_last_entry,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VERTEX_W-1:0]    out_parent_vertex,
  output logic [VERTEX_W-1:0]    out_child_vertex,
  output logic                   out_connected,
  output logic                   out_last_pair
);

  localparam int WB = WEIGHT_BITS;
  localparam int DW = WEIGHT_BITS + 1;
  localparam int MW = 2 * VW;
  localparam logic [DW-1:0] DIST_INF = '1;
  localparam logic [COUNT_W-1:0] VL_C = COUNT_W'(VL);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_NEXT     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_PICK     = 3'd3;
  localparam logic [2:0] S_RELAX    = 3'd4;
  localparam logic [2:0] S_EMIT_RD  = 3'd5;
  localparam logic [2:0] S_EMIT_LD  = 3'd6;
  localparam logic [2:0] S_EMIT_OUT = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       round_r, round_nxt;
  logic                vld_d_r, vld_d_nxt;
  logic [VW-1:0]       idx_d_r, idx_d_nxt;
  logic [DW-1:0]       least_r, least_nxt;
  logic [VW-1:0]       pick_r, pick_nxt;
  logic                found_r, found_nxt;
  logic [VL-1:0]       in_tree_r, in_tree_nxt;
  logic [VL-1:0]       reached_r, reached_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VERTEX_W-1:0] parent_r, parent_nxt;
  logic [VERTEX_W-1:0] child_r, child_nxt;
  logic                conn_r, conn_nxt;
  logic                lastp_r, lastp_nxt;

  logic          in_accept;
  logic          pos_ok;
  logic          wram_we;
  logic [MW-1:0] wram_waddr;
  logic [MW-1:0] wram_raddr;
  logic [WB-1:0] wram_rdata;
  logic          dram_we;
  logic [DW-1:0] dram_rdata;
  logic          pram_we;
  logic [VW-1:0] pram_rdata;
  logic [VW-1:0] rd_idx;
  logic [DW-1:0] cand_dist;
  logic [DW-1:0] cmp_a;
  logic [DW-1:0] cmp_b;
  logic          cmp_lt;
  logic          issue_more;
  logic          sweep_done;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign pos_ok    = ({1'b0, in_row} < VL_C) && ({1'b0, in_col} < VL_C);
  assign wram_we   = in_accept && pos_ok;
  assign wram_waddr = {in_row[VW-1:0], in_col[VW-1:0]};
  assign rd_idx     = idx_r[VW-1:0];
  assign wram_raddr = {pick_r, rd_idx};

  pmst_ram #(.WIDTH(WB), .DEPTH(1 << MW)) u_weight_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (WB'(in_weight)),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  pmst_ram #(.WIDTH(DW), .DEPTH(VL)) u_dist_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (idx_d_r),
    .wdata ({1'b0, wram_rdata}),
    .raddr (rd_idx),
    .rdata (dram_rdata)
  );

  pmst_ram #(.WIDTH(VW), .DEPTH(VL)) u_parent_ram (
    .clk   (clk),
    .we    (pram_we),
    .waddr (idx_d_r),
    .wdata (pick_r),
    .raddr (rd_idx),
    .rdata (pram_rdata)
  );

  // vertex 0 starts at distance zero, unreached vertices at the sentinel
  assign cand_dist = (idx_d_r == '0) ? '0 :
                     (reached_r[idx_d_r] ? dram_rdata : DIST_INF);

  // shared compare unit
  assign cmp_a  = (state_r == S_RELAX) ? {1'b0, wram_rdata} : cand_dist;
  assign cmp_b  = (state_r == S_RELAX) ? cand_dist : least_r;
  assign cmp_lt = cmp_a < cmp_b;

  assign issue_more = idx_r < nv;
  assign sweep_done = !issue_more && !vld_d_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    round_nxt     = round_r;
    vld_d_nxt     = vld_d_r;
    idx_d_nxt     = idx_d_r;
    least_nxt     = least_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    in_tree_nxt   = in_tree_r;
    reached_nxt   = reached_r;
    out_valid_nxt = out_valid_r;
    parent_nxt    = parent_r;
    child_nxt     = child_r;
    conn_nxt      = conn_r;
    lastp_nxt     = lastp_r;
    dram_we       = 1'b0;
    pram_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_last_entry) begin
          in_tree_nxt = '0;
          reached_nxt = '0;
          round_nxt   = '0;
          state_nxt   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (round_r + CW'(1) < nv) begin
          idx_nxt   = '0;
          vld_d_nxt = 1'b0;
          least_nxt = DIST_INF;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else if (nv > CW'(1)) begin
          idx_nxt   = CW'(1);
          state_nxt = S_EMIT_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (issue_more) begin
          idx_nxt   = idx_r + CW'(1);
          idx_d_nxt = rd_idx;
        end
        vld_d_nxt = issue_more;
        if (vld_d_r && !in_tree_r[idx_d_r] && cmp_lt) begin
          least_nxt = cand_dist;
          pick_nxt  = idx_d_r;
          found_nxt = 1'b1;
        end
        if (sweep_done) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (found_r) begin
          in_tree_nxt[pick_r] = 1'b1;
          idx_nxt             = '0;
          vld_d_nxt           = 1'b0;
          state_nxt           = S_RELAX;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = S_EMIT_RD;
        end
      end
      S_RELAX: begin
        if (issue_more) begin
          idx_nxt   = idx_r + CW'(1);
          idx_d_nxt = rd_idx;
        end
        vld_d_nxt = issue_more;
        if (vld_d_r && (wram_rdata != '0) && !in_tree_r[idx_d_r] && cmp_lt) begin
          dram_we              = 1'b1;
          pram_we              = 1'b1;
          reached_nxt[idx_d_r] = 1'b1;
        end
        if (sweep_done) begin
          round_nxt = round_r + CW'(1);
          state_nxt = S_NEXT;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        parent_nxt    = reached_r[rd_idx] ? VERTEX_W'(pram_rdata) : '0;
        child_nxt     = VERTEX_W'(idx_r);
        conn_nxt      = reached_r[rd_idx];
        lastp_nxt     = (idx_r + CW'(1) == nv);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (lastp_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_d_r     <= 1'b0;
      found_r     <= 1'b0;
      in_tree_r   <= '0;
      reached_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_d_r     <= vld_d_nxt;
      found_r     <= found_nxt;
      in_tree_r   <= in_tree_nxt;
      reached_r   <= reached_nxt;
    end
    idx_r    <= idx_nxt;
    round_r  <= round_nxt;
    idx_d_r  <= idx_d_nxt;
    least_r  <= least_nxt;
    pick_r   <= pick_nxt;
    parent_r <= parent_nxt;
    child_r  <= child_nxt;
    conn_r   <= conn_nxt;
    lastp_r  <= lastp_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_parent_vertex = parent_r;
  assign out_child_vertex  = child_r;
  assign out_connected     = conn_r;
  assign out_last_pair     = lastp_r;

endmodule
